[rtl/core/rdp_pkg.sv]
// ----------------------------------------------------------------------------
// rdp_pkg
// Shared types, register indexes, format codes and dither tables for the
// RGB888 dither packer.
// ----------------------------------------------------------------------------
package rdp_pkg;

	// Field widths
	localparam int COMP_W       = 8;
	localparam int PACKED_W     = 18;
	localparam int FMT_W        = 3;
	localparam int LINE_WIDTH_W = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = LINE_WIDTH_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DITHER_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 2'd2;

	// Pixel format codes
	localparam logic [FMT_W-1:0] FMT_444       = 3'd0;
	localparam logic [FMT_W-1:0] FMT_666       = 3'd1;
	localparam logic [FMT_W-1:0] FMT_555_ONE   = 3'd2;
	localparam logic [FMT_W-1:0] FMT_565       = 3'd3;
	localparam logic [FMT_W-1:0] FMT_555_ALPHA = 3'd4;

	// Reset values
	localparam logic [FMT_W-1:0]        PIXEL_FORMAT_RST = FMT_565;
	localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST   = 13'd640;

	// 4x4 ordered dither tables, indexed by {row, col}
	localparam logic [4:0] DITH4 [16] = '{
		5'd1,  5'd9,  5'd3,  5'd11,
		5'd13, 5'd5,  5'd15, 5'd7,
		5'd4,  5'd12, 5'd2,  5'd10,
		5'd16, 5'd8,  5'd14, 5'd6
	};
	localparam logic [4:0] DITH5 [16] = '{
		5'd1, 5'd5, 5'd2, 5'd6,
		5'd7, 5'd3, 5'd8, 5'd4,
		5'd2, 5'd6, 5'd1, 5'd5,
		5'd8, 5'd4, 5'd7, 5'd3
	};
	localparam logic [4:0] DITH6 [16] = '{
		5'd1, 5'd3, 5'd1, 5'd3,
		5'd4, 5'd2, 5'd4, 5'd2,
		5'd1, 5'd3, 5'd1, 5'd3,
		5'd4, 5'd2, 5'd4, 5'd2
	};

	// Item fields carried along the pipeline
	typedef struct packed {
		logic [COMP_W-1:0] blue;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] red;
		logic              alpha_bit;
	} pix_t;

	// Centered offsets: 444 by 8, 555 by 4, 666 by 2
	function automatic logic signed [4:0] off444(input logic [3:0] ph);
		logic [4:0] d;
		d = DITH4[ph] - 5'd8;
		return $signed(d);
	endfunction

	function automatic logic signed [4:0] off555(input logic [3:0] ph);
		logic [4:0] d;
		d = DITH5[ph] - 5'd4;
		return $signed(d);
	endfunction

	function automatic logic signed [4:0] off666(input logic [3:0] ph);
		logic [4:0] d;
		d = DITH6[ph] - 5'd2;
		return $signed(d);
	endfunction

	// Add offset and clamp to 0..255
	function automatic logic [COMP_W-1:0] shade(
		input logic [COMP_W-1:0] comp,
		input logic signed [4:0] off
	);
		logic [9:0] v;
		v = {2'b00, comp} + {{5{off[4]}}, off};
		if (v[9]) begin
			return '0;
		end else if (v[8]) begin
			return '1;
		end else begin
			return v[7:0];
		end
	endfunction

endpackage

[rtl/core/rdp_if.sv]
// ----------------------------------------------------------------------------
// rdp_if
// Valid/ready word channels: RGB888 pixel in, packed pixel out.
// ----------------------------------------------------------------------------
interface rdp_pix_in_if;
	logic                       valid;
	logic                       ready;
	logic [rdp_pkg::COMP_W-1:0] blue;
	logic [rdp_pkg::COMP_W-1:0] green;
	logic [rdp_pkg::COMP_W-1:0] red;
	logic                       alpha_bit;
	logic                       frame_start;

	modport source (output valid, blue, green, red, alpha_bit, frame_start, input ready);
	modport sink   (input valid, blue, green, red, alpha_bit, frame_start, output ready);
endinterface

interface rdp_pix_out_if;
	logic                         valid;
	logic                         ready;
	logic [rdp_pkg::PACKED_W-1:0] packed_pixel;

	modport source (output valid, packed_pixel, input ready);
	modport sink   (input valid, packed_pixel, output ready);
endinterface

[rtl/core/rgb888_dither_packer.sv]
// Accepted words pass through input register s1, then output register s2.
// Throughput: one word per cycle while pix_out.ready is high; s1 and s2 form
// a two-deep pipeline, so a stalled output holds at most two words.
// Reset (arst_n low, async): pipeline empties, column and row phase clear,
// pixel_format = 565, dither off, line_width = 640.
// ----------------------------------------------------------------------------
// rgb888_dither_packer
// Packs RGB888 pixels into 444/666/555/565 words with optional 4x4 ordered
// dithering, phase tracked by column and row counters.
// ----------------------------------------------------------------------------
module rgb888_dither_packer #(
	parameter int MAX_LINE_WIDTH = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rdp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rdp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	rdp_pix_in_if.sink                        pix_in,
	rdp_pix_out_if.source                     pix_out
);

	localparam int CNT_W = $clog2(MAX_LINE_WIDTH);
	localparam int CMP_W = (CNT_W + 1 > rdp_pkg::LINE_WIDTH_W) ? CNT_W + 1
		: rdp_pkg::LINE_WIDTH_W;
	localparam logic [CMP_W-1:0] MAX_LW = CMP_W'(MAX_LINE_WIDTH);

	// Configuration registers
	logic [rdp_pkg::FMT_W-1:0]        fmt_q;
	logic                             dith_en_q;
	logic [rdp_pkg::LINE_WIDTH_W-1:0] line_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q        <= rdp_pkg::PIXEL_FORMAT_RST;
			dith_en_q    <= 1'b0;
			line_width_q <= rdp_pkg::LINE_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rdp_pkg::REG_PIXEL_FORMAT:  fmt_q        <= cfg_wdata[rdp_pkg::FMT_W-1:0];
				rdp_pkg::REG_DITHER_ENABLE: dith_en_q    <= cfg_wdata[0];
				rdp_pkg::REG_LINE_WIDTH:    line_width_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake
	logic valid_s1, valid_s2;
	logic load_s2, in_acc;

	assign load_s2      = valid_s1 && (!valid_s2 || pix_out.ready);
	assign pix_in.ready = !valid_s1 || load_s2;
	assign in_acc       = pix_in.valid && pix_in.ready;

	// Dither phase counters
	logic [CNT_W-1:0] col_q, col_base;
	logic [1:0]       row_q, row_base;
	logic [CMP_W-1:0] lw_eff, col_inc;
	logic             wrap;

	always_comb begin
		col_base = pix_in.frame_start ? '0 : col_q;
		row_base = pix_in.frame_start ? 2'd0 : row_q;
		if (line_width_q == '0) begin
			lw_eff = CMP_W'(1);
		end else if (CMP_W'(line_width_q) > MAX_LW) begin
			lw_eff = MAX_LW;
		end else begin
			lw_eff = CMP_W'(line_width_q);
		end
		col_inc = CMP_W'(col_base) + CMP_W'(1);
		wrap    = col_inc >= lw_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= 2'd0;
		end else if (in_acc) begin
			if (wrap) begin
				col_q <= '0;
				row_q <= row_base + 2'd1;
			end else begin
				col_q <= col_inc[CNT_W-1:0];
				row_q <= row_base;
			end
		end
	end

	// Stage 1: input register with dither phase
	rdp_pkg::pix_t pix_s1;
	logic [3:0]    ph_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1.blue      <= pix_in.blue;
			pix_s1.green     <= pix_in.green;
			pix_s1.red       <= pix_in.red;
			pix_s1.alpha_bit <= pix_in.alpha_bit;
			ph_s1            <= {row_base, col_base[1:0]};
		end
	end

	// Offset selection per format
	logic signed [4:0] off_rb, off_g;
	logic [rdp_pkg::COMP_W-1:0] b_sh, g_sh, r_sh;
	logic [rdp_pkg::PACKED_W-1:0] packed_d;

	always_comb begin
		case (fmt_q)
			rdp_pkg::FMT_444: begin
				off_rb = rdp_pkg::off444(ph_s1);
				off_g  = rdp_pkg::off444(ph_s1);
			end
			rdp_pkg::FMT_666: begin
				off_rb = rdp_pkg::off666(ph_s1);
				off_g  = rdp_pkg::off666(ph_s1);
			end
			rdp_pkg::FMT_555_ONE, rdp_pkg::FMT_555_ALPHA: begin
				off_rb = rdp_pkg::off555(ph_s1);
				off_g  = rdp_pkg::off555(ph_s1);
			end
			rdp_pkg::FMT_565: begin
				off_rb = rdp_pkg::off555(ph_s1);
				off_g  = rdp_pkg::off666(ph_s1);
			end
			default: begin
				off_rb = '0;
				off_g  = '0;
			end
		endcase
		if (!dith_en_q) begin
			off_rb = '0;
			off_g  = '0;
		end
		b_sh = rdp_pkg::shade(pix_s1.blue,  off_rb);
		g_sh = rdp_pkg::shade(pix_s1.green, off_g);
		r_sh = rdp_pkg::shade(pix_s1.red,   off_rb);
	end

	// Packing
	always_comb begin
		case (fmt_q)
			rdp_pkg::FMT_444:
				packed_d = {6'b0, r_sh[7:4], g_sh[7:4], b_sh[7:4]};
			rdp_pkg::FMT_666:
				packed_d = {r_sh[7:2], g_sh[7:2], b_sh[7:2]};
			rdp_pkg::FMT_555_ONE:
				packed_d = {2'b0, 1'b1, r_sh[7:3], g_sh[7:3], b_sh[7:3]};
			rdp_pkg::FMT_555_ALPHA:
				packed_d = {2'b0, pix_s1.alpha_bit, r_sh[7:3], g_sh[7:3], b_sh[7:3]};
			rdp_pkg::FMT_565:
				packed_d = {2'b0, r_sh[7:3], g_sh[7:2], b_sh[7:3]};
			default:
				packed_d = '0;
		endcase
	end

	// Stage 2: output register
	logic [rdp_pkg::PACKED_W-1:0] packed_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || pix_out.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			packed_s2 <= packed_d;
		end
	end

	assign pix_out.valid        = valid_s2;
	assign pix_out.packed_pixel = packed_s2;

	// Checks
	a_acc_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted word missing from stage 1");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> valid_s2)
		else $error("stage 1 word lost on its way to the output");

	a_frame_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && pix_in.frame_start) |=>
			((col_q == '0 || col_q == CNT_W'(1)) && (row_q == 2'd0 || row_q == 2'd1)))
		else $error("frame start did not restart the dither phase");

	a_unused_fmt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(load_s2 && fmt_q != rdp_pkg::FMT_444 && fmt_q != rdp_pkg::FMT_666
			&& fmt_q != rdp_pkg::FMT_555_ONE && fmt_q != rdp_pkg::FMT_565
			&& fmt_q != rdp_pkg::FMT_555_ALPHA) |=> (packed_s2 == '0))
		else $error("unused format code gave a nonzero word");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !wrap) |=> (CMP_W'(col_q) < lw_eff))
		else $error("column counter passed the line width");

endmodule
